[rtl/core/scfla_pkg.sv]
// Shared types and constants for the size-class free-list allocator.
package scfla_pkg;

   localparam int SIZE_W      = 32;
   localparam int SLOT_W      = 8;
   localparam int CLASS_W     = 3;
   localparam int BUF_CLASSES = 5;
   localparam int CLASS_COUNT = 6;

   localparam logic [CLASS_W-1:0] OBJ_CLASS     = 3'd5;
   localparam logic [CLASS_W-1:0] LAST_BUF_CLASS = 3'd4;

   // Largest request, in bytes, that each buffer class can hold.
   localparam logic [SIZE_W-1:0] CLASS_LIMIT [BUF_CLASSES] = '{
      32'd16, 32'd256, 32'd4096, 32'd65536, 32'd1048576
   };

   typedef enum logic [2:0] {
      MODE_ALLOC_BUF   = 3'd0,
      MODE_FREE_BUF    = 3'd1,
      MODE_REALLOC_BUF = 3'd2,
      MODE_ALLOC_OBJ   = 3'd3,
      MODE_FREE_OBJ    = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_TOO_LARGE = 3'd2,
      ST_IGNORED   = 3'd3,
      ST_OVERFLOW  = 3'd4
   } status_type;

endpackage

[rtl/core/scfla_if.sv]
// Request and response channel interfaces of the size-class free-list allocator.
interface scfla_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] mode;
   logic [31:0] request_size;
   logic       handle_present;
   logic [2:0] handle_class;
   logic [7:0] handle_slot;

   modport source (output valid, mode, request_size, handle_present, handle_class,
                   handle_slot, input ready);
   modport sink   (input valid, mode, request_size, handle_present, handle_class,
                   handle_slot, output ready);
endinterface

interface scfla_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic       alloc_valid;
   logic [2:0] alloc_class;
   logic [7:0] alloc_slot;

   modport source (output valid, status, alloc_valid, alloc_class, alloc_slot,
                   input ready);
   modport sink   (input valid, status, alloc_valid, alloc_class, alloc_slot,
                   output ready);
endinterface

[rtl/core/size_class_free_list_allocator.sv]
// Top level of the size-class free-list allocator: six slot stacks in one memory.
//
//   Channel    Direction   Carries
//   req_chan   in          mode, request_size, handle_present, handle_class, handle_slot
//   rsp_chan   out         status, alloc_valid, alloc_class, alloc_slot
//
// One transaction is accepted per cycle while the response side is not stalled: on
// acceptance the stack counters are updated and the stack memory access is issued, and
// the middle stage then passes the memory read data into the response register.
// The single read port and single write port of the stack memory set that figure: a request
// pops at most one entry and pushes at most one entry.
// Reset is synchronous; every stack comes out full with entry i holding i.
// A stalled response holds the middle stage, and the request side then stalls as well.
module size_class_free_list_allocator #(
   parameter int SLOTS_CLASS0  = 256,
   parameter int SLOTS_CLASS1  = 128,
   parameter int SLOTS_CLASS2  = 64,
   parameter int SLOTS_CLASS3  = 16,
   parameter int SLOTS_CLASS4  = 4,
   parameter int SLOTS_OBJECTS = 256
) (
   input logic        clock,
   input logic        reset,
   scfla_req_if.sink   req_chan,
   scfla_rsp_if.source rsp_chan
);
   import scfla_pkg::*;

   // All six stacks share one memory; each class owns a contiguous region.
   localparam int TOTAL_SLOTS = SLOTS_CLASS0 + SLOTS_CLASS1 + SLOTS_CLASS2 +
                                SLOTS_CLASS3 + SLOTS_CLASS4 + SLOTS_OBJECTS;
   localparam int ADDR_W = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;

   localparam int MAX_A     = (SLOTS_CLASS0 > SLOTS_CLASS1) ? SLOTS_CLASS0 : SLOTS_CLASS1;
   localparam int MAX_B     = (SLOTS_CLASS2 > SLOTS_CLASS3) ? SLOTS_CLASS2 : SLOTS_CLASS3;
   localparam int MAX_C     = (SLOTS_CLASS4 > SLOTS_OBJECTS) ? SLOTS_CLASS4 : SLOTS_OBJECTS;
   localparam int MAX_AB    = (MAX_A > MAX_B) ? MAX_A : MAX_B;
   localparam int MAX_SLOTS = (MAX_AB > MAX_C) ? MAX_AB : MAX_C;
   localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

   localparam logic [CNT_W-1:0] CLASS_SLOTS [CLASS_COUNT] = '{
      CNT_W'(SLOTS_CLASS0), CNT_W'(SLOTS_CLASS1), CNT_W'(SLOTS_CLASS2),
      CNT_W'(SLOTS_CLASS3), CNT_W'(SLOTS_CLASS4), CNT_W'(SLOTS_OBJECTS)
   };

   localparam logic [ADDR_W-1:0] CLASS_BASE [CLASS_COUNT] = '{
      ADDR_W'(0),
      ADDR_W'(SLOTS_CLASS0),
      ADDR_W'(SLOTS_CLASS0 + SLOTS_CLASS1),
      ADDR_W'(SLOTS_CLASS0 + SLOTS_CLASS1 + SLOTS_CLASS2),
      ADDR_W'(SLOTS_CLASS0 + SLOTS_CLASS1 + SLOTS_CLASS2 + SLOTS_CLASS3),
      ADDR_W'(SLOTS_CLASS0 + SLOTS_CLASS1 + SLOTS_CLASS2 + SLOTS_CLASS3 + SLOTS_CLASS4)
   };

   // Per-class free counts and low-water marks. An entry below the low-water mark of its
   // class has never been pushed since reset, so it still holds its own index and the
   // memory is not consulted for it. This replaces a clearing pass after reset.
   logic [CNT_W-1:0] cnt_ff [CLASS_COUNT];
   logic [CNT_W-1:0] cnt_in [CLASS_COUNT];
   logic [CNT_W-1:0] lw_ff  [CLASS_COUNT];
   logic [CNT_W-1:0] lw_in  [CLASS_COUNT];

   logic [SLOT_W-1:0] stack_mem [TOTAL_SLOTS];
   logic [SLOT_W-1:0] rdata_ff;

   // Middle stage: waiting for the memory read data.
   logic               s1_valid_ff, s1_valid_in;
   status_type         s1_status_ff;
   logic               s1_alloc_ff;
   logic [CLASS_W-1:0] s1_class_ff;
   logic               s1_from_mem_ff;
   logic [SLOT_W-1:0]  s1_slot_ff;

   // Response register.
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff;
   logic               rsp_alloc_ff;
   logic [CLASS_W-1:0] rsp_class_ff;
   logic [SLOT_W-1:0]  rsp_slot_ff;

   // Decode of the transaction at the request port.
   logic               push_en;
   logic [CLASS_W-1:0] push_class;
   logic               pop_en;
   logic               pop_fwd;
   logic [CLASS_W-1:0] pop_class;
   logic [CNT_W-1:0]   pop_idx;
   logic               pop_fresh;
   status_type         req_status;
   status_type         free_status;
   logic               req_alloc;
   logic               fit;
   logic [CLASS_W-1:0] fit_class;

   logic req_accept;
   logic s1_advance;

   assign s1_advance     = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign req_accept     = req_chan.valid && req_chan.ready;

   // Smallest buffer class whose limit holds the requested size.
   always_comb begin
      fit       = 1'b0;
      fit_class = '0;
      for (int c = BUF_CLASSES - 1; c >= 0; c--) begin
         if (req_chan.request_size <= CLASS_LIMIT[c]) begin
            fit       = 1'b1;
            fit_class = CLASS_W'(c);
         end
      end
   end

   // Request decode. A realloc pushes first; when it pops from the class it just pushed
   // to, the popped entry is the freed handle, so it is forwarded without a memory read.
   always_comb begin
      push_en     = 1'b0;
      push_class  = req_chan.handle_class;
      pop_en      = 1'b0;
      pop_fwd     = 1'b0;
      pop_class   = fit_class;
      req_status  = ST_OK;
      free_status = ST_OK;
      req_alloc   = 1'b0;

      if (req_chan.handle_present) begin
         if (req_chan.handle_class > LAST_BUF_CLASS) begin
            free_status = ST_IGNORED;
         end else if (cnt_ff[req_chan.handle_class] >= CLASS_SLOTS[req_chan.handle_class])
         begin
            free_status = ST_OVERFLOW;
         end else begin
            free_status = ST_OK;
         end
      end

      unique case (req_chan.mode)
         MODE_ALLOC_BUF: begin
            if (!fit) begin
               req_status = ST_TOO_LARGE;
            end else if (cnt_ff[fit_class] == '0) begin
               req_status = ST_EMPTY;
            end else begin
               pop_en    = 1'b1;
               req_alloc = 1'b1;
            end
         end
         MODE_FREE_BUF: begin
            req_status = free_status;
            push_en    = req_chan.handle_present && (free_status == ST_OK);
         end
         MODE_REALLOC_BUF: begin
            push_en = req_chan.handle_present && (free_status == ST_OK);
            if (!fit) begin
               req_status = ST_TOO_LARGE;
            end else if (push_en && (push_class == fit_class)) begin
               pop_fwd    = 1'b1;
               req_alloc  = 1'b1;
               req_status = free_status;
            end else if (cnt_ff[fit_class] == '0) begin
               req_status = ST_EMPTY;
            end else begin
               pop_en     = 1'b1;
               req_alloc  = 1'b1;
               req_status = free_status;
            end
         end
         MODE_ALLOC_OBJ: begin
            pop_class = OBJ_CLASS;
            if (cnt_ff[OBJ_CLASS] == '0) begin
               req_status = ST_EMPTY;
            end else begin
               pop_en    = 1'b1;
               req_alloc = 1'b1;
            end
         end
         MODE_FREE_OBJ: begin
            push_class = OBJ_CLASS;
            if (req_chan.handle_present) begin
               if (cnt_ff[OBJ_CLASS] >= CLASS_SLOTS[OBJ_CLASS]) begin
                  req_status = ST_OVERFLOW;
               end else begin
                  push_en = 1'b1;
               end
            end
         end
         default: begin
            req_status = ST_IGNORED;
         end
      endcase
   end

   assign pop_idx   = cnt_ff[pop_class] - CNT_W'(1);
   assign pop_fresh = pop_idx < lw_ff[pop_class];

   // Counter and low-water updates; a forwarded realloc leaves its class count unchanged.
   always_comb begin
      for (int c = 0; c < CLASS_COUNT; c++) begin
         cnt_in[c] = cnt_ff[c];
         lw_in[c]  = lw_ff[c];
         if (push_en && !pop_fwd && (push_class == CLASS_W'(c))) begin
            cnt_in[c] = cnt_ff[c] + CNT_W'(1);
         end
         if (pop_en && (pop_class == CLASS_W'(c))) begin
            cnt_in[c] = cnt_ff[c] - CNT_W'(1);
            if (pop_fresh) begin
               lw_in[c] = pop_idx;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CLASS_COUNT; c++) begin
            cnt_ff[c] <= CLASS_SLOTS[c];
            lw_ff[c]  <= CLASS_SLOTS[c];
         end
      end else if (req_accept) begin
         cnt_ff <= cnt_in;
         lw_ff  <= lw_in;
      end
   end

   // Stack memory: one write port for pushes, one registered read port for pops.
   always_ff @(posedge clock) begin
      if (req_accept && push_en) begin
         stack_mem[CLASS_BASE[push_class] + ADDR_W'(cnt_ff[push_class])] <= req_chan.handle_slot;
      end
      if (req_accept && pop_en) begin
         rdata_ff <= stack_mem[CLASS_BASE[pop_class] + ADDR_W'(pop_idx)];
      end
   end

   // Pipeline control.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_status_ff   <= req_status;
         s1_alloc_ff    <= req_alloc;
         s1_class_ff    <= req_alloc ? pop_class : '0;
         s1_from_mem_ff <= pop_en && !pop_fresh;
         s1_slot_ff     <= pop_fwd ? req_chan.handle_slot : SLOT_W'(pop_idx);
      end
      if (s1_advance) begin
         rsp_status_ff <= s1_status_ff;
         rsp_alloc_ff  <= s1_alloc_ff;
         rsp_class_ff  <= s1_class_ff;
         if (!s1_alloc_ff) begin
            rsp_slot_ff <= '0;
         end else if (s1_from_mem_ff) begin
            rsp_slot_ff <= rdata_ff;
         end else begin
            rsp_slot_ff <= s1_slot_ff;
         end
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.alloc_valid = rsp_alloc_ff;
   assign rsp_chan.alloc_class = rsp_class_ff;
   assign rsp_chan.alloc_slot  = rsp_slot_ff;

   // A held middle stage must stall the request side.
   a_stall_backs_up: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_chan.ready |-> !req_chan.ready)
      else $error("request accepted while the middle stage is held");

   // A handed-out slot never comes with an alloc error; a realloc may still report its free.
   a_alloc_ok: assert property (@(posedge clock) disable iff (reset)
      s1_advance && s1_alloc_ff |=> (rsp_status_ff != ST_EMPTY) &&
                                    (rsp_status_ff != ST_TOO_LARGE))
      else $error("slot handed out with an alloc error status");

   for (genvar g = 0; g < CLASS_COUNT; g++) begin : g_class_chk
      // No class ever holds more free entries than it has slots.
      a_count_bound: assert property (@(posedge clock) disable iff (reset)
         cnt_ff[g] <= CLASS_SLOTS[g])
         else $error("free count above class size");

      // The low-water mark never rises above the free count.
      a_low_water: assert property (@(posedge clock) disable iff (reset)
         lw_ff[g] <= cnt_ff[g])
         else $error("low-water mark above free count");
   end

endmodule
